/* sv/assert_macros.svh */
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTQ_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/dtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    typedef enum logic [1:0]
    {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_EXPIRE = 2'd2
    } kind_t;

    localparam int RESULTS_MAX = 16;
    localparam int BURST_W     = $clog2(RESULTS_MAX);
    localparam int DELAY_W     = 32;
    localparam int CID_W       = 16;
    localparam int RID_W       = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 24;

    typedef struct packed
    {
        logic load;
        logic scan_start;
        logic commit;
        logic last;
    } dtq_ctrl_t;

    typedef struct packed
    {
        cmd_t op;
        logic scan_done;
        logic found;
        logic due_one;
        logic out_free;
    } dtq_stat_t;

endpackage

`default_nettype wire

/* sv/dtq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  cmd_t      s_cmd,
    output logic      s_tready,
    input  dtq_stat_t stat,
    output dtq_ctrl_t ctrl
);

    typedef enum logic [2:0]
    {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic               last_now;

    always_comb
    begin
        state_next = state_reg;
        burst_next = burst_reg;
        ctrl       = '0;
        last_now   = 1'b0;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load  = 1'b1;
                    burst_next = '0;
                    if (s_cmd != CMD_NONE)
                    begin
                        ctrl.scan_start = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    if (stat.op == CMD_TICK)
                    begin
                        if (!stat.found)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            last_now = stat.due_one ||
                                       (burst_reg == BURST_W'(RESULTS_MAX - 1));
                            ctrl.commit = 1'b1;
                            ctrl.last   = last_now;
                            if (last_now)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                burst_next      = burst_reg + 1'b1;
                                ctrl.scan_start = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        ctrl.commit = 1'b1;
                        ctrl.last   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            burst_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            burst_reg <= burst_next;
        end
    end

endmodule

`default_nettype wire

/* sv/dtq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  cmd_t                  s_cmd,
    input  dtq_ctrl_t             ctrl,
    output dtq_stat_t             stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    cmd_t                 op_reg, op_next;
    logic [DELAY_W-1:0]   delay_reg;
    logic [CID_W-1:0]     cid_reg;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic [DEPTH-1:0]     valid_reg, valid_next;

    logic [TIME_BITS-1:0] mem_dl [DEPTH];
    logic [ID_BITS-1:0]   mem_id [DEPTH];
    logic [TIME_BITS-1:0] rd_dl_reg;
    logic [ID_BITS-1:0]   rd_id_reg;

    logic                 issue_active_reg, issue_active_next;
    logic [IDX_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg;

    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     sel_idx_reg, sel_idx_next;
    logic [TIME_BITS-1:0] best_dl_reg, best_dl_next;
    logic [ID_BITS-1:0]   best_id_reg, best_id_next;
    logic [1:0]           due_cnt_reg, due_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [RID_W-1:0]     out_id_reg, out_id_next;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 cand_live;
    logic                 hit;
    logic                 take;
    logic [ID_BITS-1:0]   want_id;
    logic [TIME_BITS:0]   dl_sum;
    logic [TIME_BITS-1:0] new_dl;

    assign out_free = !out_valid_reg || m_tready;
    assign want_id  = ID_BITS'(cid_reg);
    assign dl_sum   = {1'b0, now_reg} + (TIME_BITS + 1)'(delay_reg);
    assign new_dl   = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];
    assign cand_live = cmp_valid_reg && valid_reg[cmp_idx_reg];

    always_comb
    begin
        hit  = 1'b0;
        take = 1'b0;
        case (op_reg)
            CMD_ADD:
            begin
                hit  = cmp_valid_reg && !valid_reg[cmp_idx_reg];
                take = hit && !found_reg;
            end
            CMD_CANCEL:
            begin
                hit  = cand_live && (rd_id_reg == want_id);
                take = hit && !found_reg;
            end
            CMD_TICK:
            begin
                hit  = cand_live && (rd_dl_reg <= now_reg);
                take = hit && (!found_reg || (rd_dl_reg < best_dl_reg) ||
                       ((rd_dl_reg == best_dl_reg) && (rd_id_reg < best_id_reg)));
            end
            default:
            begin
                hit  = 1'b0;
                take = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next           = op_reg;
        now_next          = now_reg;
        next_id_next      = next_id_reg;
        valid_next        = valid_reg;
        issue_active_next = issue_active_reg;
        issue_idx_next    = issue_idx_reg;
        cmp_valid_next    = issue_active_reg;
        found_next        = found_reg;
        sel_idx_next      = sel_idx_reg;
        best_dl_next      = best_dl_reg;
        best_id_next      = best_id_reg;
        due_cnt_next      = due_cnt_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_kind_next     = out_kind_reg;
        out_id_next       = out_id_reg;
        out_ok_next       = out_ok_reg;
        out_last_next     = out_last_reg;

        if (ctrl.load)
        begin
            op_next = s_cmd;
            if ((s_cmd == CMD_TICK) && (now_reg != TIME_MAX))
            begin
                now_next = now_reg + 1'b1;
            end
        end

        if (issue_active_reg)
        begin
            if (issue_idx_reg == LAST_IDX)
            begin
                issue_active_next = 1'b0;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
            end
        end

        if (take)
        begin
            found_next   = 1'b1;
            sel_idx_next = cmp_idx_reg;
            best_dl_next = rd_dl_reg;
            best_id_next = rd_id_reg;
        end
        if (hit && (op_reg == CMD_TICK) && !due_cnt_reg[1])
        begin
            due_cnt_next = due_cnt_reg + 1'b1;
        end

        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = ctrl.last;
            case (op_reg)
                CMD_ADD:
                begin
                    out_kind_next = KIND_ADD;
                    out_ok_next   = found_reg;
                    if (found_reg)
                    begin
                        valid_next[sel_idx_reg] = 1'b1;
                        next_id_next            = next_id_reg + 1'b1;
                        out_id_next             = RID_W'(next_id_reg);
                    end
                    else
                    begin
                        out_id_next = '0;
                    end
                end
                CMD_CANCEL:
                begin
                    out_kind_next = KIND_CANCEL;
                    out_ok_next   = found_reg;
                    out_id_next   = cid_reg;
                    if (found_reg)
                    begin
                        valid_next[sel_idx_reg] = 1'b0;
                    end
                end
                default:
                begin
                    out_kind_next           = KIND_EXPIRE;
                    out_ok_next             = 1'b1;
                    out_id_next             = RID_W'(best_id_reg);
                    valid_next[sel_idx_reg] = 1'b0;
                end
            endcase
        end

        if (ctrl.scan_start)
        begin
            issue_active_next = 1'b1;
            issue_idx_next    = '0;
            found_next        = 1'b0;
            due_cnt_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg           <= CMD_NONE;
            now_reg          <= '0;
            next_id_reg      <= '0;
            valid_reg        <= '0;
            issue_active_reg <= 1'b0;
            issue_idx_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            due_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            op_reg           <= op_next;
            now_reg          <= now_next;
            next_id_reg      <= next_id_next;
            valid_reg        <= valid_next;
            issue_active_reg <= issue_active_next;
            issue_idx_reg    <= issue_idx_next;
            cmp_valid_reg    <= cmp_valid_next;
            found_reg        <= found_next;
            due_cnt_reg      <= due_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            delay_reg <= s_tdata[DELAY_W-1:0];
            cid_reg   <= s_tdata[DELAY_W +: CID_W];
        end
        cmp_idx_reg   <= issue_idx_reg;
        sel_idx_reg   <= sel_idx_next;
        best_dl_reg   <= best_dl_next;
        best_id_reg   <= best_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit && (op_reg == CMD_ADD) && found_reg)
        begin
            mem_dl[sel_idx_reg] <= new_dl;
            mem_id[sel_idx_reg] <= next_id_reg;
        end
        if (issue_active_reg)
        begin
            rd_dl_reg <= mem_dl[issue_idx_reg];
            rd_id_reg <= mem_id[issue_idx_reg];
        end
    end

    assign stat.op        = op_reg;
    assign stat.scan_done = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign stat.found     = found_reg;
    assign stat.due_one   = (due_cnt_reg == 2'd1);
    assign stat.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - RID_W - 1)'(0), out_ok_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* sv/deadline_timer_queue.sv */
// One-shot timer queue with DEPTH entries. Each request on the slave side is an add, a
// cancel, a tick or a no-op (taken with no reply); the others are answered on the master side:
// an add returns the id it assigned (ok low with id zero when the table is full), a cancel
// echoes the id and reports whether a live entry was removed, and a tick advances time by
// one and then returns every due entry as an expiry, earliest deadline first and the smaller
// id first on a tie, at most sixteen per tick, with tlast on the final one (a tick with
// nothing due returns nothing). Every add, cancel or tick is served by a scan of the entry
// table memory, one entry per clock cycle; a tick scans the table anew for every expiry
// after the first, and no new request is taken until the last one is done. The block
// accepts the next request while the last result still waits in its output register.

`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // delay[31:0], cancel_id[47:32]
    input  logic [1:0]            s_tuser,   // cmd[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // result_id[15:0], ok[16], zero[23:17]
    output logic [1:0]            m_tuser,   // kind[1:0]
    output logic                  m_tlast
);

    cmd_t      s_cmd;
    dtq_ctrl_t ctrl;
    dtq_stat_t stat;

    assign s_cmd = cmd_t'(s_tuser);

    dtq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_cmd),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    dtq_datapath #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_cmd    (s_cmd),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/dtq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dtq_checker
    import dtq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser,
    input logic                  m_tlast
);

    `DTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "Stalled result changed.")
    `DTQ_ASSERT_NEXT(a_busy_after_request, clk, rst_n, s_tvalid && s_tready && (s_tuser != CMD_NONE), !s_tready, "Request accepted while a scan was running.")
    `DTQ_ASSERT_IMPL(a_expire_ok, clk, rst_n, m_tvalid && (m_tuser == KIND_EXPIRE), m_tdata[RID_W], "Expiry result without ok.")
    `DTQ_ASSERT_IMPL(a_reply_last, clk, rst_n, m_tvalid && (m_tuser != KIND_EXPIRE), m_tlast, "Add or cancel reply not marked last.")

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);

`default_nettype wire

/* tb/tb_deadline_timer_queue.sv */
`timescale 1ns / 1ps

module tb_deadline_timer_queue;

    import dtq_pkg::*;

    localparam int SLOTS         = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [47:0] TIME_MAX = '1;

    typedef enum logic [2:0]
    {
        STEP_REQ,
        STEP_DRAIN,
        STEP_HOLD,
        STEP_STEADY_ON,
        STEP_STEADY_OFF
    } step_t;

    typedef struct
    {
        step_t       tag;
        cmd_t        op;
        logic [31:0] dly;
        logic [15:0] cid;
    } timer_req_t;

    typedef struct
    {
        kind_t       kind;
        logic [15:0] rid;
        logic        ok;
        logic        last;
    } timer_reply_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    timer_req_t   requests_todo[$];
    timer_reply_t replies_due[$];

    logic [47:0] clock_now = '0;
    logic [15:0] id_next   = '0;
    logic        slot_live [SLOTS] = '{default: 1'b0};
    logic [47:0] slot_due  [SLOTS] = '{default: '0};
    logic [15:0] slot_tag  [SLOTS] = '{default: '0};

    logic req_taken = 1'b0;
    logic draining  = 1'b0;
    logic steady    = 1'b0;
    int   hold_seq  = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;
    int   mismatches = 0;
    int   adds_queued = 0;

    wire req_fire = s_tvalid && s_tready;
    wire res_fire = m_tvalid && m_tready;

    deadline_timer_queue dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_request(input cmd_t op, input logic [31:0] dly, input logic [15:0] cid);
        requests_todo.push_back('{STEP_REQ, op, dly, cid});
        if (op == CMD_ADD)
            adds_queued++;
    endtask

    task automatic queue_marker(input step_t tag);
        requests_todo.push_back('{tag, CMD_NONE, 32'd0, 16'd0});
    endtask

    task automatic queue_random_requests(input int count);
        int pick;
        int lo;
        logic [31:0] dly;
        logic [15:0] cid;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            dly = $urandom;
            cid = $urandom;
            if (pick < 38)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    dly = $urandom_range(0, 10);
                else if (pick < 85)
                    dly = $urandom_range(11, 200);
                queue_request(CMD_ADD, dly, cid);
            end
            else if (pick < 58)
            begin
                lo = adds_queued > 24 ? adds_queued - 24 : 0;
                if ($urandom_range(0, 99) < 70)
                    cid = $urandom_range(lo, adds_queued);
                queue_request(CMD_CANCEL, dly, cid);
            end
            else if (pick < 95)
                queue_request(CMD_TICK, dly, cid);
            else
                queue_request(CMD_NONE, dly, cid);
        end
    endtask

    // Updates the timer table for one accepted request and queues the replies it causes.
    task automatic model_request(input cmd_t op, input logic [31:0] dly, input logic [15:0] cid);
        int slot;
        int best;
        int n;
        logic [48:0] sum;
        logic found;
        logic have_prev;
        timer_reply_t prev;
        slot = -1;
        found = 1'b0;
        case (op)
            CMD_ADD:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        slot = i;
                if (slot < 0)
                    replies_due.push_back('{KIND_ADD, 16'd0, 1'b0, 1'b1});
                else
                begin
                    sum = {1'b0, clock_now} + {17'd0, dly};
                    slot_due[slot] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[47:0];
                    slot_tag[slot] = id_next;
                    slot_live[slot] = 1'b1;
                    replies_due.push_back('{KIND_ADD, id_next, 1'b1, 1'b1});
                    id_next = id_next + 16'd1;
                end
            end
            CMD_CANCEL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && slot_live[i] && slot_tag[i] == cid)
                    begin
                        slot_live[i] = 1'b0;
                        found = 1'b1;
                    end
                end
                replies_due.push_back('{KIND_CANCEL, cid, found, 1'b1});
            end
            CMD_TICK:
            begin
                if (clock_now != TIME_MAX)
                    clock_now = clock_now + 48'd1;
                have_prev = 1'b0;
                n = 0;
                best = 0;
                while (n < RESULTS_MAX && best >= 0)
                begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_live[i] && slot_due[i] <= clock_now)
                        begin
                            if (best < 0 || slot_due[i] < slot_due[best] ||
                                (slot_due[i] == slot_due[best] && slot_tag[i] < slot_tag[best]))
                                best = i;
                        end
                    end
                    if (best >= 0)
                    begin
                        slot_live[best] = 1'b0;
                        if (have_prev)
                            replies_due.push_back(prev);
                        prev = '{KIND_EXPIRE, slot_tag[best], 1'b1, 1'b0};
                        have_prev = 1'b1;
                        n++;
                    end
                end
                if (have_prev)
                begin
                    prev.last = 1'b1;
                    replies_due.push_back(prev);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(negedge clk)
    begin
        timer_req_t nxt;
        logic offer;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || req_taken)
        begin
            offer = 1'b0;
            if (draining && replies_due.size() == 0)
                draining = 1'b0;
            while (!draining && requests_todo.size() != 0 && requests_todo[0].tag != STEP_REQ)
            begin
                nxt = requests_todo.pop_front();
                case (nxt.tag)
                    STEP_DRAIN:      draining = 1'b1;
                    STEP_HOLD:       hold_seq <= hold_seq + 1;
                    STEP_STEADY_ON:  steady <= 1'b1;
                    STEP_STEADY_OFF: steady <= 1'b0;
                    default:
                    begin
                    end
                endcase
            end
            if (!draining && requests_todo.size() != 0 &&
                (steady || $urandom_range(0, 99) >= 37))
            begin
                nxt = requests_todo.pop_front();
                s_tdata <= {nxt.cid, nxt.dly};
                s_tuser <= nxt.op;
                offer = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge clk)
    begin
        timer_reply_t want;
        req_taken <= req_fire;
        if (rst_n && req_fire)
            model_request(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]);
        if (rst_n && res_fire)
        begin
            if (replies_due.size() == 0)
                report_mismatch("unexpected result id", m_tdata[15:0], 0);
            else
            begin
                want = replies_due.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[15:0] !== want.rid)
                    report_mismatch("result_id", m_tdata[15:0], want.rid);
                if (m_tdata[16] !== want.ok)
                    report_mismatch("ok", m_tdata[16], want.ok);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || req_fire || res_fire)
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        queue_request(CMD_TICK, 32'd0, 16'd0);
        queue_request(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_request(CMD_CANCEL, 32'd0, 16'hFFFF);
        queue_request(CMD_ADD, 32'd0, 16'd0);
        queue_request(CMD_ADD, 32'd1, 16'd0);
        queue_request(CMD_ADD, 32'd1, 16'd0);
        queue_request(CMD_ADD, 32'hFFFF_FFFF, 16'd0);
        queue_request(CMD_TICK, 32'd0, 16'd0);
        queue_request(CMD_CANCEL, 32'd0, 16'd3);
        queue_request(CMD_CANCEL, 32'd0, 16'd3);
        // Sixteen entries due on the same tick fill the table and expire as one burst.
        for (int k = 0; k < SLOTS; k++)
            queue_request(CMD_ADD, 32'd1, 16'd0);
        queue_request(CMD_ADD, 32'd5, 16'd0);
        queue_request(CMD_TICK, 32'd0, 16'd0);

        queue_random_requests(50);
        queue_marker(STEP_HOLD);
        queue_random_requests(20);
        queue_marker(STEP_DRAIN);
        queue_marker(STEP_STEADY_ON);
        queue_random_requests(40);
        queue_marker(STEP_STEADY_OFF);
        queue_random_requests(20);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (requests_todo.size() != 0 || s_tvalid)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
